FILE: rtl/ccrng_pkg.sv
// ============================================================================
// ccrng_pkg: shared types and constants for the ChaCha20 random generator
// Request codes, status codes, controller commands and the quarter round.
// ============================================================================
package ccrng_pkg;

	localparam int BufferBlocks = 16;
	localparam int BufWords     = BufferBlocks * 16;
	localparam int BufBytes     = BufferBlocks * 64;
	localparam int BufAw        = $clog2(BufWords);
	localparam int UnreadW      = $clog2(BufBytes + 1);
	localparam int BlkW         = $clog2(BufferBlocks + 1);
	localparam int SeedBytes    = 40;
	localparam int MixWords     = SeedBytes / 8;
	localparam logic [31:0] DefaultInterval = 32'd1600000;

	localparam logic [1:0] REQ_WORD    = 2'd0;
	localparam logic [1:0] REQ_SEED    = 2'd1;
	localparam logic [1:0] REQ_ENTROPY = 2'd2;

	localparam logic [1:0] ST_WORD  = 2'd0;
	localparam logic [1:0] ST_NEED  = 2'd1;
	localparam logic [1:0] ST_CHUNK = 2'd2;

	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646e;
	localparam logic [31:0] Sigma2 = 32'h79622d32;
	localparam logic [31:0] Sigma3 = 32'h6b206574;

	// Command from controller to datapath
	typedef struct packed {
		logic       blk_start;    // load block input state, zero round count
		logic       round_step;   // one half round (column or diagonal)
		logic       blk_store;    // write word (feed-forward) into buffer
		logic       rekey_load;   // read key words out of buffer
		logic       mix_en;       // xor collected bytes into the new key
		logic       seed_load;    // key straight from mix buffer
		logic       clr_mix;
		logic       clr_buf_step; // zero one buffer word
		logic       word_read;    // issue read for next word
		logic       word_take;    // capture word, zero entry
		logic       add_byte;     // add one chunk byte
		logic       finish_seed;  // restore budget, seeded, unread 0
		logic       set_unread;   // unread after rekey
		logic       dec_budget;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic seeded;
		logic budget_low;
		logic unread_low;
		logic mix_full;
		logic mix_empty;
		logic rounds_done;
		logic blk_end;
		logic store_done;
		logic key_done;
		logic clr_done;
	} sts_t;

	function automatic logic [127:0] qr(input logic [127:0] v);
		logic [31:0] a, b, c, d;
		a = v[31:0]; b = v[63:32]; c = v[95:64]; d = v[127:96];
		a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
		c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
		a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
		c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
		return {d, c, b, a};
	endfunction

endpackage

FILE: rtl/ccrng_ram.sv
// ============================================================================
// ccrng_ram: generic single-port RAM
// One access per cycle: a read with an optional write, read data registered.
// ============================================================================
module ccrng_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

FILE: rtl/ccrng_dp.sv
// ============================================================================
// ccrng_dp: ChaCha20 datapath
// Key state, a round unit of four quarter rounds (one column or diagonal half
// round per cycle), keystream RAM, mix collector, budget and read pointer.
// ============================================================================
module ccrng_dp
	import ccrng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [31:0] interval,
	input  logic [63:0] chunk_data,
	input  logic [2:0]  byte_idx,
	output logic [31:0] word_out
);
	logic [31:0]  key_q [8];
	logic [63:0]  nonce_q, ctr_q;
	logic [31:0]  x_q [16];
	logic [4:0]   rnd_q;       // half rounds done
	logic [3:0]   wsel_q;      // word within block / key word
	logic [BlkW-1:0]  blk_q;
	logic [BufAw-1:0] clr_q;
	logic [UnreadW-1:0] unread_q;
	logic [31:0]  budget_q;
	logic         seeded_q;
	logic [63:0]  mix_q [MixWords];
	logic [5:0]   fill_q;
	logic         rd_pend_q;

	logic [31:0] in_w [16];
	logic [31:0] ram_rd;
	logic        ram_we;
	logic [BufAw-1:0] ram_a;
	logic [31:0] ram_wd;
	logic [31:0] mixw [10];
	logic [3:0]  kidx;
	logic [31:0] kmix;
	logic [BufAw-1:0] widx;

	always_comb begin
		in_w[0] = Sigma0; in_w[1] = Sigma1; in_w[2] = Sigma2; in_w[3] = Sigma3;
		for (int i = 0; i < 8; i++) in_w[4+i] = key_q[i];
		in_w[12] = ctr_q[31:0];  in_w[13] = ctr_q[63:32];
		in_w[14] = nonce_q[31:0]; in_w[15] = nonce_q[63:32];
		for (int i = 0; i < 10; i++)
			mixw[i] = mix_q[i >> 1][32*(i & 1) +: 32];
	end

	// mix word for the key word captured this cycle; none for a plain rekey
	assign kidx = wsel_q - 4'd1;
	assign kmix = (cmd.mix_en && kidx < 4'd10) ? mixw[kidx] : 32'd0;

	assign widx = BufAw'((BufBytes - unread_q) >> 2);

	// RAM address and write data
	always_comb begin
		ram_we = 1'b0;
		ram_a  = widx;
		ram_wd = '0;
		if (cmd.blk_store) begin
			ram_we = 1'b1;
			ram_a  = BufAw'({blk_q, wsel_q});
			ram_wd = x_q[wsel_q] + in_w[wsel_q];
		end else if (cmd.clr_buf_step) begin
			ram_we = 1'b1;
			ram_a  = clr_q;
		end else if (cmd.rekey_load) begin
			// read each of the first ten words and zero it in the same access
			ram_we = wsel_q < 4'd10;
			ram_a  = BufAw'(wsel_q);
		end else if (cmd.word_take) begin
			ram_we = 1'b1;
		end
	end

	ccrng_ram #(.Width(32), .Depth(BufWords)) u_buf (
		.clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_rd));

	assign word_out = ram_rd;

	// Double-round unit: column half then diagonal half
	always_ff @(posedge clk) begin
		logic [127:0] r0, r1, r2, r3;
		if (cmd.blk_start) begin
			for (int i = 0; i < 16; i++) x_q[i] <= in_w[i];
		end else if (cmd.round_step) begin
			if (!rnd_q[0]) begin
				r0 = qr({x_q[12], x_q[8], x_q[4], x_q[0]});
				r1 = qr({x_q[13], x_q[9], x_q[5], x_q[1]});
				r2 = qr({x_q[14], x_q[10], x_q[6], x_q[2]});
				r3 = qr({x_q[15], x_q[11], x_q[7], x_q[3]});
				{x_q[12], x_q[8], x_q[4], x_q[0]} <= r0;
				{x_q[13], x_q[9], x_q[5], x_q[1]} <= r1;
				{x_q[14], x_q[10], x_q[6], x_q[2]} <= r2;
				{x_q[15], x_q[11], x_q[7], x_q[3]} <= r3;
			end else begin
				r0 = qr({x_q[15], x_q[10], x_q[5], x_q[0]});
				r1 = qr({x_q[12], x_q[11], x_q[6], x_q[1]});
				r2 = qr({x_q[13], x_q[8], x_q[7], x_q[2]});
				r3 = qr({x_q[14], x_q[9], x_q[4], x_q[3]});
				{x_q[15], x_q[10], x_q[5], x_q[0]} <= r0;
				{x_q[12], x_q[11], x_q[6], x_q[1]} <= r1;
				{x_q[13], x_q[8], x_q[7], x_q[2]} <= r2;
				{x_q[14], x_q[9], x_q[4], x_q[3]} <= r3;
			end
		end
	end

	// Control registers of the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) key_q[i] <= '0;
			for (int i = 0; i < MixWords; i++) mix_q[i] <= '0;
			nonce_q <= '0; ctr_q <= '0; rnd_q <= '0; wsel_q <= '0; blk_q <= '0;
			clr_q <= '0; unread_q <= '0; budget_q <= '0;
			seeded_q <= 1'b0; fill_q <= '0; rd_pend_q <= 1'b0;
		end else begin
			if (cmd.blk_start) rnd_q <= '0;
			else if (cmd.round_step) rnd_q <= rnd_q + 5'd1;
			// block store sweep
			if (cmd.blk_store) begin
				wsel_q <= wsel_q + 4'd1;
				if (wsel_q == 4'd15) begin
					blk_q <= blk_q + BlkW'(1);
					ctr_q <= ctr_q + 64'd1;
				end
			end
			// read first ten words back as key, xor mix, zero them
			if (cmd.rekey_load) begin
				if (rd_pend_q) begin
					if (wsel_q <= 4'd8)
						key_q[kidx[2:0]] <= ram_rd ^ kmix;
					else if (wsel_q == 4'd9)
						nonce_q[31:0] <= ram_rd ^ kmix;
					else
						nonce_q[63:32] <= ram_rd ^ kmix;
				end
				if (wsel_q == 4'd10) begin
					rd_pend_q <= 1'b0;
					wsel_q <= '0;
					blk_q <= '0;
					ctr_q <= '0;
				end else begin
					rd_pend_q <= 1'b1;
					wsel_q <= wsel_q + 4'd1;
				end
			end
			if (cmd.seed_load) begin
				for (int i = 0; i < 8; i++) key_q[i] <= mixw[i];
				nonce_q <= {mixw[9], mixw[8]};
				ctr_q <= '0;
				seeded_q <= 1'b1;
			end
			if (cmd.clr_mix) begin
				for (int i = 0; i < MixWords; i++) mix_q[i] <= '0;
				fill_q <= '0;
			end else if (cmd.add_byte && fill_q < 6'(SeedBytes)) begin
				mix_q[fill_q[5:3]][8*fill_q[2:0] +: 8] <= chunk_data[8*byte_idx +: 8];
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.clr_buf_step) clr_q <= clr_q + BufAw'(1);
			if (cmd.set_unread) unread_q <= UnreadW'(BufBytes - SeedBytes);
			else if (cmd.finish_seed) unread_q <= '0;
			else if (cmd.word_take) unread_q <= unread_q - UnreadW'(4);
			if (cmd.finish_seed) begin
				budget_q <= interval;
				seeded_q <= 1'b1;
			end else if (cmd.dec_budget) budget_q <= budget_q - 32'd4;
		end
	end

	assign sts.seeded      = seeded_q;
	assign sts.budget_low  = budget_q <= 32'd4;
	assign sts.unread_low  = unread_q < UnreadW'(4);
	assign sts.mix_full    = fill_q >= 6'(SeedBytes);
	assign sts.mix_empty   = fill_q == '0;
	assign sts.rounds_done = rnd_q == 5'd19;
	assign sts.blk_end     = wsel_q == 4'd15;
	assign sts.store_done  = wsel_q == 4'd15 && blk_q == BlkW'(BufferBlocks - 1);
	assign sts.key_done    = wsel_q == 4'd10;
	assign sts.clr_done    = clr_q == BufAw'(BufWords - 1);
endmodule

FILE: rtl/ccrng_ctrl.sv
// ============================================================================
// ccrng_ctrl: request sequencer
// Decodes requests, runs rekey, seed keying, buffer clear and word reads.
// ============================================================================
module ccrng_ctrl
	import ccrng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [3:0]  chunk_bytes,
	input  logic        chunk_last,
	output logic [2:0]  byte_idx,
	output cmd_t        cmd,
	input  sts_t        sts,
	output logic        res_valid,
	output logic        res_word,
	output logic [1:0]  res_status
);
	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_BYTES  = 10'b0000000010,
		S_BSTART = 10'b0000000100,
		S_ROUND  = 10'b0000001000,
		S_STORE  = 10'b0000010000,
		S_KEY    = 10'b0000100000,
		S_CLEAR  = 10'b0001000000,
		S_RDADDR = 10'b0010000000,
		S_RDTAKE = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] type_q, type_d;
	logic [3:0] n_q, n_d;
	logic       last_q, last_d;
	logic [2:0] bi_q, bi_d;
	logic       after_q, after_d;   // rekey return: 0 to bytes loop, 1 to end
	logic       clr_pend_q, clr_pend_d;
	logic       ent_block;          // entropy byte waits for an overflow rekey

	assign byte_idx = bi_q;
	assign in_ready = state_q == S_IDLE;
	assign ent_block = type_q == REQ_ENTROPY && sts.mix_full;

	// Next state, commands and results
	always_comb begin
		cmd = '0;
		state_d = state_q;
		type_d = type_q; n_d = n_q; last_d = last_q; bi_d = bi_q;
		after_d = after_q; clr_pend_d = clr_pend_q;
		res_valid = 1'b0; res_word = 1'b0; res_status = ST_CHUNK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					type_d = req_type;
					n_d    = (chunk_bytes > 4'd8) ? 4'd8 : chunk_bytes;
					last_d = chunk_last;
					bi_d   = '0;
					clr_pend_d = 1'b0;
					after_d = 1'b0;
					case (req_type)
						REQ_WORD: begin
							if (sts.seeded && !sts.budget_low) begin
								cmd.dec_budget = 1'b1;
								after_d = 1'b1;
								state_d = sts.unread_low ? S_BSTART : S_RDADDR;
							end
						end
						REQ_SEED: state_d = S_BYTES;
						REQ_ENTROPY: if (sts.seeded) state_d = S_BYTES;
						default: ;
					endcase
				end
			end
			S_BYTES: begin
				// one chunk byte per cycle; entropy overflow triggers a rekey
				if (n_q != 4'd0 && ent_block) begin
					state_d = S_BSTART;
				end else begin
					if (n_q != 4'd0) begin
						cmd.add_byte = 1'b1;
						bi_d = bi_q + 3'd1;
					end
					// chunk end once all bytes are in; the group ends with the last chunk
					if (n_q == 4'd0 || {1'b0, bi_q} == n_q - 4'd1) begin
						if (!last_q) state_d = S_DONE;
						else if (type_q == REQ_SEED) begin
							clr_pend_d = 1'b1;
							state_d = sts.seeded ? S_BSTART : S_CLEAR;
						end else if (sts.mix_empty && n_q == 4'd0) begin
							state_d = S_DONE;
						end else begin
							after_d = 1'b1;
							state_d = S_BSTART;
						end
					end
				end
			end
			S_BSTART: begin cmd.blk_start = 1'b1; state_d = S_ROUND; end
			S_ROUND: begin
				cmd.round_step = 1'b1;
				if (sts.rounds_done) state_d = S_STORE;
			end
			S_STORE: begin
				cmd.blk_store = 1'b1;
				if (sts.store_done) state_d = S_KEY;
				else if (sts.blk_end) state_d = S_BSTART;
			end
			S_KEY: begin
				cmd.rekey_load = 1'b1;
				cmd.mix_en = type_q != REQ_WORD;
				if (sts.key_done) begin
					cmd.set_unread = 1'b1;
					cmd.clr_mix = type_q != REQ_WORD;
					if (type_q == REQ_WORD) state_d = S_RDADDR;
					else if (clr_pend_q) state_d = S_CLEAR;
					else if (after_q) state_d = S_DONE;
					else state_d = S_BYTES;
				end
			end
			S_CLEAR: begin
				cmd.clr_buf_step = 1'b1;
				cmd.seed_load = clr_pend_q && !sts.seeded;
				if (sts.clr_done) begin
					cmd.clr_mix = 1'b1;
					cmd.finish_seed = 1'b1;
					state_d = S_DONE;
				end
			end
			S_RDADDR: begin cmd.word_read = 1'b1; state_d = S_RDTAKE; end
			S_RDTAKE: begin
				cmd.word_take = 1'b1;
				res_valid = 1'b1; res_word = 1'b1; res_status = ST_WORD;
				state_d = S_IDLE;
			end
			S_DONE: begin res_valid = 1'b1; state_d = S_IDLE; end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; type_q <= REQ_WORD; n_q <= '0; last_q <= 1'b0;
			bi_q <= '0; after_q <= 1'b0; clr_pend_q <= 1'b0;
		end else begin
			state_q <= state_d; type_q <= type_d; n_q <= n_d; last_q <= last_d;
			bi_q <= bi_d; after_q <= after_d; clr_pend_q <= clr_pend_d;
		end
	end
endmodule

FILE: rtl/chacha20_keystream_random_generator_top.sv
// ============================================================================
// chacha20_keystream_random_generator_top: ChaCha20 CSPRNG, fast key erasure
// Word requests, seed and entropy chunks in; one result per request out.
// ============================================================================
// A word from the buffer passes the read-address and take states and is then
// registered as the result; a rekey first runs every buffer block through the
// single round unit. A chunk's bytes go into the mix one per cycle unless an
// entropy overflow rekey holds them; a seed group end adds a clear of the buffer.
// One request at a time: a new one is taken only once the last result is taken.
// Reset (arst_n low) unseeds the generator; interval resets to 1600000.
module chacha20_keystream_random_generator_top
	import ccrng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // req_type[1:0], chunk_data[65:2], chunk_bytes[69:66]
	input  logic        s_tlast,  // chunk_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // random_word[31:0], word_valid[32], status[34:33]
);
	logic [31:0] interval_q;
	cmd_t        cmd;
	sts_t        sts;
	logic [2:0]  byte_idx;
	logic [31:0] word;
	logic        ctl_ready, res_valid, res_word;
	logic [1:0]  res_status;
	logic        out_v_q;
	logic [34:0] out_q;
	logic        in_v;
	logic [63:0] chunk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) interval_q <= DefaultInterval;
		else if (cfg_we) interval_q <= cfg_wdata;
	end

	// accept only when result register is free
	assign in_v     = s_tvalid && !out_v_q;
	assign s_tready = ctl_ready && !out_v_q;

	// chunk bytes held for the byte loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chunk_q <= '0;
		else if (in_v && ctl_ready) chunk_q <= s_tdata[65:2];
	end

	ccrng_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(in_v), .in_ready(ctl_ready),
		.req_type(s_tdata[1:0]), .chunk_bytes(s_tdata[69:66]),
		.chunk_last(s_tlast), .byte_idx, .cmd, .sts,
		.res_valid, .res_word, .res_status);

	ccrng_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .interval(interval_q),
		.chunk_data(chunk_q), .byte_idx, .word_out(word));

	// immediate results (need seed, unknown type) and sequenced results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else if (out_v_q) begin
			if (m_tready) out_v_q <= 1'b0;
		end else if (res_valid) begin
			out_v_q <= 1'b1;
			out_q   <= {res_status, res_word, res_word ? word : 32'd0};
		end else if (in_v && ctl_ready) begin
			if ((s_tdata[1:0] == REQ_WORD && (!sts.seeded || sts.budget_low)) ||
			    (s_tdata[1:0] == REQ_ENTROPY && !sts.seeded)) begin
				out_v_q <= 1'b1;
				out_q   <= {ST_NEED, 1'b0, 32'd0};
			end else if (s_tdata[1:0] == 2'd3) begin
				out_v_q <= 1'b1;
				out_q   <= {ST_CHUNK, 1'b0, 32'd0};
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_q};
endmodule

FILE: rtl/ccrng_checker.sv
// ============================================================================
// ccrng_checker: port-level checks for the random generator
// Result coding and handshake behavior seen at the top-level ports.
// ============================================================================
module ccrng_checker
	import ccrng_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);
	// word flag agrees with status
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[32] == (m_tdata[34:33] == ST_WORD)))
		else $error("word_valid and status disagree");

	// no word value without word flag
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0)
		else $error("nonzero word without word_valid");

	// no new request taken while a result waits
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request accepted while result pending");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
endmodule

bind chacha20_keystream_random_generator_top ccrng_checker u_chk (
	.clk, .arst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata);

FILE: test/ccrng_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccrng_scoreboard: response checker for the ChaCha20 random generator
// Watches the request and response streams and the config port, keeps its own
// generator state, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module ccrng_scoreboard
	import ccrng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] word;
		logic        valid;
		logic [1:0]  status;
	} resp_t;

	resp_t resp_q[$];

	// Generator state
	logic [31:0] interval;
	logic [31:0] key_w[8];
	logic [63:0] nonce;
	logic [63:0] blk_ctr;
	logic [31:0] kbuf[BufWords];
	int unsigned unread;
	logic [31:0] budget;
	bit          seeded;
	logic [63:0] pool[5];
	int unsigned pool_fill;
	logic [31:0] wk[16];

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter(input int a, input int b, input int c, input int d);
		wk[a] = wk[a] + wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 16);
		wk[c] = wk[c] + wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 12);
		wk[a] = wk[a] + wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 8);
		wk[c] = wk[c] + wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 7);
	endfunction

	// One 20-round block into kbuf at word offset base
	function automatic void gen_block(input int base);
		logic [31:0] init[16];
		init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
		for (int i = 0; i < 8; i++) init[4 + i] = key_w[i];
		init[12] = blk_ctr[31:0];
		init[13] = blk_ctr[63:32];
		init[14] = nonce[31:0];
		init[15] = nonce[63:32];
		for (int i = 0; i < 16; i++) wk[i] = init[i];
		for (int r = 0; r < 10; r++) begin
			quarter(0, 4, 8, 12); quarter(1, 5, 9, 13);
			quarter(2, 6, 10, 14); quarter(3, 7, 11, 15);
			quarter(0, 5, 10, 15); quarter(1, 6, 11, 12);
			quarter(2, 7, 8, 13); quarter(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) kbuf[base + i] = wk[i] + init[i];
		blk_ctr = blk_ctr + 64'd1;
	endfunction

	function automatic logic [31:0] pool_word(input int i);
		return 32'(pool[i >> 1] >> (32 * (i & 1)));
	endfunction

	function automatic void load_key(input logic [31:0] w[10]);
		for (int i = 0; i < 8; i++) key_w[i] = w[i];
		nonce = {w[9], w[8]};
		blk_ctr = '0;
	endfunction

	function automatic void clear_pool();
		for (int i = 0; i < 5; i++) pool[i] = '0;
		pool_fill = 0;
	endfunction

	function automatic void refill(input bit with_pool);
		logic [31:0] w[10];
		for (int b = 0; b < BufferBlocks; b++) gen_block(b * 16);
		for (int i = 0; i < 10; i++) begin
			if (with_pool) kbuf[i] = kbuf[i] ^ pool_word(i);
			w[i] = kbuf[i];
		end
		load_key(w);
		for (int i = 0; i < 10; i++) kbuf[i] = '0;
		unread = BufBytes - SeedBytes;
	endfunction

	function automatic void add_byte(input logic [7:0] v);
		if (pool_fill < SeedBytes) begin
			pool[pool_fill >> 3] = pool[pool_fill >> 3] | (64'(v) << (8 * (pool_fill & 7)));
			pool_fill++;
		end
	endfunction

	function automatic void reset_state();
		interval = DefaultInterval;
		for (int i = 0; i < 8; i++) key_w[i] = '0;
		nonce = '0;
		blk_ctr = '0;
		for (int i = 0; i < BufWords; i++) kbuf[i] = '0;
		unread = 0;
		budget = '0;
		seeded = 0;
		clear_pool();
	endfunction

	// Expected response to one request; updates the generator state
	function automatic resp_t predict_response(input logic [1:0] kind, input logic [63:0] data,
			input logic [3:0] nb, input logic last);
		resp_t r;
		int unsigned n;
		int unsigned idx;
		logic [31:0] w[10];
		r.word = '0; r.valid = 0; r.status = ST_CHUNK;
		n = (nb > 8) ? 8 : nb;
		case (kind)
			REQ_WORD: begin
				if (!seeded || budget <= 4) begin
					r.status = ST_NEED;
				end else begin
					budget = budget - 4;
					if (unread < 4 || unread > BufBytes) refill(0);
					idx = (BufBytes - unread) >> 2;
					if (idx < BufWords) begin
						r.word = kbuf[idx];
						kbuf[idx] = '0;
					end
					unread = unread - 4;
					r.valid = 1;
					r.status = ST_WORD;
				end
			end
			REQ_SEED: begin
				for (int k = 0; k < n; k++) add_byte(data[8 * k +: 8]);
				if (last) begin
					if (!seeded) begin
						for (int i = 0; i < 10; i++) w[i] = pool_word(i);
						load_key(w);
						seeded = 1;
					end else begin
						refill(1);
					end
					clear_pool();
					for (int i = 0; i < BufWords; i++) kbuf[i] = '0;
					unread = 0;
					budget = interval;
				end
			end
			REQ_ENTROPY: begin
				if (!seeded) begin
					r.status = ST_NEED;
				end else begin
					for (int k = 0; k < n; k++) begin
						if (pool_fill >= SeedBytes) begin
							refill(1);
							clear_pool();
						end
						add_byte(data[8 * k +: 8]);
					end
					if (last && pool_fill > 0) begin
						refill(1);
						clear_pool();
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Predict on request accept, compare on response accept
	always @(posedge clk or negedge arst_n) begin
		resp_t exp_r;
		resp_t got;
		int    nerr;
		nerr = 0;
		if (!arst_n) begin
			reset_state();
			resp_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) interval = cfg_wdata;
			if (s_tvalid && s_tready)
				resp_q.push_back(predict_response(s_tdata[1:0], s_tdata[65:2],
					s_tdata[69:66], s_tlast));
			if (m_tvalid && m_tready) begin
				got.word = m_tdata[31:0];
				got.valid = m_tdata[32];
				got.status = m_tdata[34:33];
				if (resp_q.size() == 0) begin
					$error("unexpected response %h", m_tdata);
					nerr++;
				end else begin
					exp_r = resp_q.pop_front();
					if (got.word !== exp_r.word) begin
						$error("random_word expected %h got %h", exp_r.word, got.word);
						nerr++;
					end
					if (got.valid !== exp_r.valid) begin
						$error("word_valid expected %b got %b", exp_r.valid, got.valid);
						nerr++;
					end
					if (got.status !== exp_r.status) begin
						$error("status expected %0d got %0d", exp_r.status, got.status);
						nerr++;
					end
				end
			end
			errors <= errors + nerr;
			pending <= resp_q.size();
		end
	end

endmodule

FILE: test/tb_chacha20_keystream_random_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha20_keystream_random_generator_top: generator testbench
// Directed seed, entropy and word requests, then random traffic under several
// reseed intervals, with random stalls on both streams and one long hold-off.
// ----------------------------------------------------------------------------
module tb_chacha20_keystream_random_generator_top;
	import ccrng_pkg::*;

	localparam int QuietLimit = 20000;
	localparam int DrainCycles = 1300;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	int          errors;
	int          pending;
	int          quiet;
	bit          no_gaps;

	chacha20_keystream_random_generator_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	ccrng_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Watchdog: too long with no transfer on either stream
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet == QuietLimit) begin
			$display("chacha20_keystream_random_generator_top: mismatch");
			$finish;
		end
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 12);
	endfunction

	// Response side: random stalls, one long hold-off after 100 responses
	initial begin
		int gap;
		int got;
		got = 0;
		m_tready = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = (got == 100) ? 300 : draw_gap();
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
			got++;
		end
	end

	task automatic send_req(input logic [1:0] kind, input logic [63:0] data,
			input logic [3:0] nb, input logic last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {2'b00, nb, data, kind};
		s_tlast <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic rand_data(output logic [63:0] d);
		d = {$urandom, $urandom};
	endtask

	// Idle the block, then write the reseed interval
	task automatic set_interval(input logic [31:0] v);
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_seed();
		logic [63:0] d;
		rand_data(d);
		send_req(REQ_SEED, d, 4'd8, 1'b1);
	endtask

	// Random requests; word_pct sets the share of word requests
	task automatic random_run(input int count, input int word_pct);
		logic [63:0] d;
		int pick;
		logic [3:0] nb;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			rand_data(d);
			pick = $urandom_range(0, 99);
			nb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(1, 8));
			if (pick < word_pct)
				send_req(REQ_WORD, d, nb, $urandom_range(0, 1));
			else if (pick < word_pct + (100 - word_pct) / 3)
				send_req(REQ_SEED, d, nb, $urandom_range(0, 2) == 0);
			else if (pick < 98)
				send_req(REQ_ENTROPY, d, nb, $urandom_range(0, 3) == 0);
			else
				send_req(REQ_SPARE, d, nb, $urandom_range(0, 1));
		end
		no_gaps = 0;
	endtask

	initial begin
		logic [63:0] d;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		no_gaps = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Unseeded: word and entropy need a seed, spare code is just accepted
		send_req(REQ_WORD, '1, 4'd8, 1'b1);
		send_req(REQ_ENTROPY, '1, 4'd8, 1'b1);
		send_req(REQ_SPARE, '1, 4'd15, 1'b1);
		// First seed: empty chunk, oversized count, exactly 40 bytes in all
		send_req(REQ_SEED, '1, 4'd8, 1'b0);
		send_req(REQ_SEED, '1, 4'd0, 1'b0);
		send_req(REQ_SEED, '0, 4'd15, 1'b0);
		for (int i = 0; i < 3; i++) begin
			rand_data(d);
			send_req(REQ_SEED, d, 4'd8, i == 2);
		end
		repeat (3) send_req(REQ_WORD, '0, 4'd0, 1'b0);
		// Entropy past 40 bytes forces a mid-group refill
		for (int i = 0; i < 6; i++) begin
			rand_data(d);
			send_req(REQ_ENTROPY, d, 4'd8, i == 5);
		end
		// Mixed groups: last chunk kind decides
		rand_data(d);
		send_req(REQ_ENTROPY, d, 4'd4, 1'b0);
		send_req(REQ_SEED, d, 4'd3, 1'b1);
		send_req(REQ_SEED, d, 4'd5, 1'b0);
		send_req(REQ_ENTROPY, d, 4'd2, 1'b1);
		repeat (2) send_req(REQ_WORD, '0, 4'd0, 1'b0);

		// Tiny budgets: one word then need-seed, or never a word
		set_interval(32'd5);
		send_seed();
		repeat (2) send_req(REQ_WORD, '0, 4'd0, 1'b0);
		set_interval(32'd4);
		send_seed();
		send_req(REQ_WORD, '0, 4'd0, 1'b0);
		set_interval(32'd0);
		send_seed();
		send_req(REQ_WORD, '0, 4'd0, 1'b0);
		set_interval(32'd1);
		send_seed();
		send_req(REQ_WORD, '0, 4'd0, 1'b0);

		// Mixed random traffic, then a long word run to drain the buffer
		set_interval(32'hFFFF_FFFF);
		send_seed();
		random_run(330, 70);
		set_interval(32'd600);
		send_seed();
		random_run(60, 90);
		set_interval(DefaultInterval);
		send_seed();
		random_run(300, 99);

		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("chacha20_keystream_random_generator_top: match");
		else
			$display("chacha20_keystream_random_generator_top: mismatch");
		$finish;
	end

endmodule
